@@ src/height_color_ramp_macros.svh @@
// Assertion macros used by the height color ramp RTL.
`ifndef HEIGHT_COLOR_RAMP_MACROS_SVH
`define HEIGHT_COLOR_RAMP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define HCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hcr_pkg.sv @@
// Types, widths and constants of the height color ramp.
package hcr_pkg;

  localparam int HEIGHT_W   = 16;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RGB_W;
  localparam int FRAC_W     = 16;
  localparam int CONT_W     = 2 * FRAC_W;
  localparam int DIV_W      = HEIGHT_W + 1;
  localparam int WIDE_W     = CONT_W + 2;
  localparam int PROD_W     = CH_W + FRAC_W + 2;

  localparam logic signed [DIV_W:0] ONE_Q15 = 18'sd32768;
  localparam logic [FRAC_W:0]       ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    ZONE_WATER,
    ZONE_LOWLAND,
    ZONE_LOW_MID,
    ZONE_MID_HIGH
  } zone_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEA_LEVEL,
    REG_LOW_LEVEL,
    REG_MIDDLE_LEVEL,
    REG_HIGH_LEVEL,
    REG_WATER_RGB,
    REG_LOWLAND_RGB,
    REG_MIDLAND_RGB,
    REG_HIGHLAND_RGB
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t  rgb;
    zone_t zone;
  } pixel_t;

  localparam logic signed [HEIGHT_W-1:0] SEA_LEVEL_RESET    = 16'sd0;
  localparam logic signed [HEIGHT_W-1:0] LOW_LEVEL_RESET    = 16'sd6554;
  localparam logic signed [HEIGHT_W-1:0] MIDDLE_LEVEL_RESET = 16'sd16384;
  localparam logic signed [HEIGHT_W-1:0] HIGH_LEVEL_RESET   = 16'sd29491;
  localparam rgb_t WATER_RGB_RESET    = 24'h0000FF;
  localparam rgb_t LOWLAND_RGB_RESET  = 24'h00FF00;
  localparam rgb_t MIDLAND_RGB_RESET  = 24'h808000;
  localparam rgb_t HIGHLAND_RGB_RESET = 24'hFFFFFF;

endpackage

@@ src/hcr_stream_if.sv @@
// Valid/ready channels for height samples and for pixels.
interface hcr_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hcr_pkg::HEIGHT_W-1:0]   height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink (input valid, input height_sample, output ready);
endinterface

interface hcr_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [hcr_pkg::CH_W-1:0]    red;
  logic [hcr_pkg::CH_W-1:0]    green;
  logic [hcr_pkg::CH_W-1:0]    blue;
  hcr_pkg::zone_t              zone;

  modport source (output valid, output red, output green, output blue, output zone,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input zone,
                output ready);
endinterface

@@ src/hcr_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
module hcr_div_pipe #(
  parameter int Q_W = 16,
  parameter int D_W = 17,
  parameter int S_W = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [D_W-1:0] rem_in,
  input  logic [Q_W-1:0] num_in,
  input  logic [D_W-1:0] div_in,
  input  logic [S_W-1:0] side_in,
  output logic           out_valid,
  output logic [Q_W-1:0] quo,
  output logic [S_W-1:0] side_out
);

  logic [Q_W-1:0] v;
  logic [D_W-1:0] rem      [Q_W];
  logic [D_W-1:0] rem_next [Q_W];
  logic [D_W-1:0] div_r    [Q_W];
  logic [D_W-1:0] div_next [Q_W];
  logic [Q_W-1:0] num      [Q_W];
  logic [Q_W-1:0] num_next [Q_W];
  logic [Q_W-1:0] quo_r    [Q_W];
  logic [Q_W-1:0] quo_next [Q_W];
  logic [S_W-1:0] side_r   [Q_W];
  logic [S_W-1:0] side_next[Q_W];

  // Remainder stays below the divisor, so one compare and subtract per bit.
  always_comb begin
    logic [D_W:0]   t;
    logic           ge;
    logic [D_W-1:0] s_rem;
    logic [D_W-1:0] s_div;
    logic [Q_W-1:0] s_num;
    logic [Q_W-1:0] s_quo;
    logic [S_W-1:0] s_side;
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        s_rem  = rem_in;
        s_div  = div_in;
        s_num  = num_in;
        s_quo  = '0;
        s_side = side_in;
      end else begin
        s_rem  = rem[i-1];
        s_div  = div_r[i-1];
        s_num  = num[i-1];
        s_quo  = quo_r[i-1];
        s_side = side_r[i-1];
      end
      t  = {s_rem, s_num[Q_W-1]};
      ge = (t >= {1'b0, s_div});
      rem_next[i]  = ge ? D_W'(t - {1'b0, s_div}) : t[D_W-1:0];
      div_next[i]  = s_div;
      num_next[i]  = {s_num[Q_W-2:0], 1'b0};
      quo_next[i]  = {s_quo[Q_W-2:0], ge};
      side_next[i] = s_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_W; i++) begin
        rem[i]    <= rem_next[i];
        div_r[i]  <= div_next[i];
        num[i]    <= num_next[i];
        quo_r[i]  <= quo_next[i];
        side_r[i] <= side_next[i];
      end
    end
  end

  assign out_valid = v[Q_W-1];
  assign quo       = quo_r[Q_W-1];
  assign side_out  = side_r[Q_W-1];

endmodule

@@ src/height_color_ramp.sv @@
// Height color ramp: maps a signed Q1.15 height sample to an RGB pixel and zone.
// A sample passes stage P, the land fraction divider, stages Z and X, the blend divider
// and stage M before the output register; one sample per clock while the skid slot is empty.
// The 32-stage land fraction and 16-stage blend dividers resolve one quotient bit per stage.
// A blocked output parks one pixel in a skid slot; the pipe holds while it is full.
// Reset clears all valid bits and loads the register reset values.
`include "height_color_ramp_macros.svh"

module height_color_ramp (
  input  logic                              clk,
  input  logic                              rst,
  hcr_sample_if.sink                        sample,
  hcr_pixel_if.source                       pixel,
  input  logic                              cfg_write_en,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int HEIGHT_W = hcr_pkg::HEIGHT_W;
  localparam int CH_W     = hcr_pkg::CH_W;
  localparam int RGB_W    = hcr_pkg::RGB_W;
  localparam int FRAC_W   = hcr_pkg::FRAC_W;
  localparam int CONT_W   = hcr_pkg::CONT_W;
  localparam int DIV_W    = hcr_pkg::DIV_W;
  localparam int SUM_W    = DIV_W + 1;
  localparam int WIDE_W   = hcr_pkg::WIDE_W;
  localparam int PROD_W   = hcr_pkg::PROD_W;

  // configuration registers
  logic signed [HEIGHT_W-1:0] sea_level;
  logic signed [HEIGHT_W-1:0] low_level;
  logic signed [HEIGHT_W-1:0] middle_level;
  logic signed [HEIGHT_W-1:0] high_level;
  hcr_pkg::rgb_t              water_rgb;
  hcr_pkg::rgb_t              lowland_rgb;
  hcr_pkg::rgb_t              midland_rgb;
  hcr_pkg::rgb_t              highland_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      sea_level    <= hcr_pkg::SEA_LEVEL_RESET;
      low_level    <= hcr_pkg::LOW_LEVEL_RESET;
      middle_level <= hcr_pkg::MIDDLE_LEVEL_RESET;
      high_level   <= hcr_pkg::HIGH_LEVEL_RESET;
      water_rgb    <= hcr_pkg::WATER_RGB_RESET;
      lowland_rgb  <= hcr_pkg::LOWLAND_RGB_RESET;
      midland_rgb  <= hcr_pkg::MIDLAND_RGB_RESET;
      highland_rgb <= hcr_pkg::HIGHLAND_RGB_RESET;
    end else if (cfg_write_en) begin
      case (hcr_pkg::cfg_reg_t'(cfg_index))
        hcr_pkg::REG_SEA_LEVEL:    sea_level    <= cfg_data[HEIGHT_W-1:0];
        hcr_pkg::REG_LOW_LEVEL:    low_level    <= cfg_data[HEIGHT_W-1:0];
        hcr_pkg::REG_MIDDLE_LEVEL: middle_level <= cfg_data[HEIGHT_W-1:0];
        hcr_pkg::REG_HIGH_LEVEL:   high_level   <= cfg_data[HEIGHT_W-1:0];
        hcr_pkg::REG_WATER_RGB:    water_rgb    <= cfg_data[RGB_W-1:0];
        hcr_pkg::REG_LOWLAND_RGB:  lowland_rgb  <= cfg_data[RGB_W-1:0];
        hcr_pkg::REG_MIDLAND_RGB:  midland_rgb  <= cfg_data[RGB_W-1:0];
        hcr_pkg::REG_HIGHLAND_RGB: highland_rgb <= cfg_data[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // levels scaled to 16 fraction bits, and the blend divisors
  logic signed [WIDE_W-1:0] low2;
  logic signed [WIDE_W-1:0] mid2;
  logic signed [WIDE_W-1:0] high2;
  logic signed [WIDE_W-1:0] den_a;
  logic signed [WIDE_W-1:0] den_b;
  logic signed [SUM_W-1:0]  land_div;

  assign low2     = WIDE_W'(low_level) <<< 1;
  assign mid2     = WIDE_W'(middle_level) <<< 1;
  assign high2    = WIDE_W'(high_level) <<< 1;
  assign den_a    = mid2 - low2;
  assign den_b    = high2 - mid2;
  assign land_div = hcr_pkg::ONE_Q15 - SUM_W'(sea_level);

  // output register and skid slot
  logic            o_v;
  logic            s_v;
  hcr_pkg::pixel_t o_pix;
  hcr_pkg::pixel_t s_pix;
  logic            en;

  assign en           = !s_v;
  assign sample.ready = en;

  // stage P: height relative to sea
  logic signed [DIV_W-1:0] h_rel;
  logic                    p_v;
  logic                    p_water;
  logic [HEIGHT_W-1:0]     p_num;
  logic [DIV_W-1:0]        p_div;

  assign h_rel = DIV_W'(sample.height_sample) - DIV_W'(sea_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_water <= h_rel[DIV_W-1];
      p_num   <= h_rel[HEIGHT_W-1:0];
      p_div   <= land_div[DIV_W-1:0];
    end
  end

  // land fraction divider
  logic              c_v;
  logic [CONT_W-1:0] cont;
  logic              c_water;

  hcr_div_pipe #(
    .Q_W (CONT_W),
    .D_W (DIV_W),
    .S_W (1)
  ) u_land_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_v),
    .rem_in    ({DIV_W{1'b0}}),
    .num_in    ({p_num, {FRAC_W{1'b0}}}),
    .div_in    (p_div),
    .side_in   (p_water),
    .out_valid (c_v),
    .quo       (cont),
    .side_out  (c_water)
  );

  // stage Z: zone from the signs of the distances to the levels
  logic signed [WIDE_W-1:0] xa;
  logic signed [WIDE_W-1:0] xb;
  hcr_pkg::zone_t           zone_next;
  logic                     z_v;
  hcr_pkg::zone_t           z_zone;
  logic signed [WIDE_W-1:0] z_xa;
  logic signed [WIDE_W-1:0] z_xb;

  assign xa = $signed(WIDE_W'(cont)) - low2;
  assign xb = $signed(WIDE_W'(cont)) - mid2;

  always_comb begin
    if (c_water) begin
      zone_next = hcr_pkg::ZONE_WATER;
    end else if (xa[WIDE_W-1]) begin
      zone_next = hcr_pkg::ZONE_LOWLAND;
    end else if (xb[WIDE_W-1]) begin
      zone_next = hcr_pkg::ZONE_LOW_MID;
    end else begin
      zone_next = hcr_pkg::ZONE_MID_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z_v <= 1'b0;
    end else if (en) begin
      z_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_zone <= zone_next;
      z_xa   <= xa;
      z_xb   <= xb;
    end
  end

  // stage X: blend numerator, divisor and clamp
  logic             sat_next;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] div_next;
  logic             x_v;
  hcr_pkg::zone_t   x_zone;
  logic             x_sat;
  logic [DIV_W-1:0] x_rem;
  logic [DIV_W-1:0] x_div;

  // Feed a harmless zero over one when no blend divide is needed.
  always_comb begin
    sat_next = 1'b0;
    rem_next = '0;
    div_next = DIV_W'(1);
    case (z_zone)
      hcr_pkg::ZONE_LOW_MID: begin
        rem_next = z_xa[DIV_W-1:0];
        div_next = den_a[DIV_W-1:0];
      end
      hcr_pkg::ZONE_MID_HIGH: begin
        sat_next = (den_b <= 0) || (z_xb >= den_b);
        if (!sat_next) begin
          rem_next = z_xb[DIV_W-1:0];
          div_next = den_b[DIV_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_v <= 1'b0;
    end else if (en) begin
      x_v <= z_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_zone <= z_zone;
      x_sat  <= sat_next;
      x_rem  <= rem_next;
      x_div  <= div_next;
    end
  end

  // blend fraction divider
  logic              f_v;
  logic [FRAC_W-1:0] f_quo;
  logic [2:0]        f_side;
  hcr_pkg::zone_t    f_zone;
  logic              f_sat;

  hcr_div_pipe #(
    .Q_W (FRAC_W),
    .D_W (DIV_W),
    .S_W (3)
  ) u_blend_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x_v),
    .rem_in    (x_rem),
    .num_in    ({FRAC_W{1'b0}}),
    .div_in    (x_div),
    .side_in   ({x_zone, x_sat}),
    .out_valid (f_v),
    .quo       (f_quo),
    .side_out  (f_side)
  );

  assign f_zone = hcr_pkg::zone_t'(f_side[2:1]);
  assign f_sat  = f_side[0];

  // stage M: color pair and per-channel products
  logic [FRAC_W:0]          frac;
  hcr_pkg::rgb_t            col_a;
  hcr_pkg::rgb_t            col_b;
  logic signed [PROD_W-1:0] prod_next [3];
  logic                     m_v;
  hcr_pkg::zone_t           m_zone;
  hcr_pkg::rgb_t            m_base;
  logic signed [PROD_W-1:0] m_prod [3];

  assign frac = f_sat ? hcr_pkg::ONE_Q16 : {1'b0, f_quo};

  // Flat zones blend a color with itself.
  always_comb begin
    case (f_zone)
      hcr_pkg::ZONE_WATER: begin
        col_a = water_rgb;
        col_b = water_rgb;
      end
      hcr_pkg::ZONE_LOWLAND: begin
        col_a = lowland_rgb;
        col_b = lowland_rgb;
      end
      hcr_pkg::ZONE_LOW_MID: begin
        col_a = lowland_rgb;
        col_b = midland_rgb;
      end
      hcr_pkg::ZONE_MID_HIGH: begin
        col_a = midland_rgb;
        col_b = highland_rgb;
      end
      default: begin
        col_a = water_rgb;
        col_b = water_rgb;
      end
    endcase
  end

  always_comb begin
    logic [CH_W-1:0]       ca;
    logic [CH_W-1:0]       cb;
    logic signed [CH_W:0]  d;
    for (int ch = 0; ch < 3; ch++) begin
      ca = col_a[RGB_W-1-ch*CH_W -: CH_W];
      cb = col_b[RGB_W-1-ch*CH_W -: CH_W];
      d  = $signed({1'b0, cb}) - $signed({1'b0, ca});
      prod_next[ch] = PROD_W'(d) * PROD_W'($signed({1'b0, frac}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_zone <= f_zone;
      m_base <= col_a;
      for (int ch = 0; ch < 3; ch++) begin
        m_prod[ch] <= prod_next[ch];
      end
    end
  end

  // final add and truncation toward zero
  hcr_pkg::pixel_t res;
  logic            push;

  always_comb begin
    logic signed [PROD_W-1:0] acc;
    res.zone = m_zone;
    res.rgb  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = $signed({2'b00, m_base[RGB_W-1-ch*CH_W -: CH_W], {FRAC_W{1'b0}}}) + m_prod[ch];
      res.rgb[RGB_W-1-ch*CH_W -: CH_W] = acc[FRAC_W +: CH_W];
    end
  end

  assign push = m_v && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      s_v <= 1'b0;
    end else if (!o_v || pixel.ready) begin
      if (s_v) begin
        o_v <= 1'b1;
        s_v <= 1'b0;
      end else begin
        o_v <= push;
      end
    end else if (push) begin
      s_v <= 1'b1;
    end
  end

  // Load the output register, or park a pixel in the skid slot while the output transaction is blocked.
  always_ff @(posedge clk) begin
    if (!o_v || pixel.ready) begin
      if (s_v) begin
        o_pix <= s_pix;
      end else if (push) begin
        o_pix <= res;
      end
    end else if (push) begin
      s_pix <= res;
    end
  end

  assign pixel.valid = o_v;
  assign pixel.red   = o_pix.rgb.red;
  assign pixel.green = o_pix.rgb.green;
  assign pixel.blue  = o_pix.rgb.blue;
  assign pixel.zone  = o_pix.zone;

  `HCR_ASSERT_IMPL(a_skid_behind_out, s_v, o_v, "skid slot full with output register empty")
  `HCR_ASSERT_NEXT(a_blocked_push_kept, push && o_v && !pixel.ready, s_v, "blocked pixel dropped")
  `HCR_ASSERT_IMPL(a_low_mid_no_clamp, x_v && x_zone == hcr_pkg::ZONE_LOW_MID, !x_sat, "low to mid fraction clamped")
  `HCR_ASSERT_IMPL(a_blend_rem_below, x_v && x_zone == hcr_pkg::ZONE_MID_HIGH && !x_sat, x_rem < x_div, "blend numerator not below divisor")

endmodule

@@ verif/tb_height_color_ramp.sv @@
// Self-checking testbench of height_color_ramp: random heights and settings against a predictor.
module tb_height_color_ramp;
  import hcr_pkg::*;

  localparam longint FRAC_ONE    = 65536;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     PHASE_ITEMS = 230;
  localparam int     MAX_REPORTS = 100;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hcr_sample_if height_ch();
  hcr_pixel_if  pixel_ch();

  height_color_ramp dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (height_ch),
    .pixel        (pixel_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Settings as the block should hold them.
  logic signed [HEIGHT_W-1:0] sea_lvl  = SEA_LEVEL_RESET;
  logic signed [HEIGHT_W-1:0] low_lvl  = LOW_LEVEL_RESET;
  logic signed [HEIGHT_W-1:0] mid_lvl  = MIDDLE_LEVEL_RESET;
  logic signed [HEIGHT_W-1:0] high_lvl = HIGH_LEVEL_RESET;
  rgb_t water_c    = WATER_RGB_RESET;
  rgb_t lowland_c  = LOWLAND_RGB_RESET;
  rgb_t midland_c  = MIDLAND_RGB_RESET;
  rgb_t highland_c = HIGHLAND_RGB_RESET;

  // Every zone and its edges under the reset settings.
  int corner_heights[14] = '{-32768, -16384, -1, 0, 1, 6553, 6554, 10000, 16383, 16384,
                             20000, 29490, 29491, 32767};

  logic [HEIGHT_W-1:0] pending_heights[$];
  pixel_t              expected_pixels[$];
  int  heights_issued = 0;
  int  heights_accepted = 0;
  int  pixels_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 13;
  int  recv_idle_pct = 55;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  height_taken = 1'b0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    height_ch.valid = 1'b0;
    height_ch.height_sample = '0;
    pixel_ch.ready = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                                  longint f);
    longint num;
    num = longint'(a) * FRAC_ONE + (longint'(b) - longint'(a)) * f;
    if (num < 0) num = 0;
    return num[23:16];
  endfunction

  function automatic rgb_t blend_pixel(rgb_t c0, rgb_t c1, longint f);
    rgb_t px;
    px.red   = mix_channel(c0.red, c1.red, f);
    px.green = mix_channel(c0.green, c1.green, f);
    px.blue  = mix_channel(c0.blue, c1.blue, f);
    return px;
  endfunction

  function automatic pixel_t shade_height(logic signed [HEIGHT_W-1:0] h);
    longint hh, sea, land, low2, mid2, high2, den, f;
    pixel_t px;
    hh = h;
    sea = sea_lvl;
    if (hh < sea) begin
      px.rgb = water_c;
      px.zone = ZONE_WATER;
      return px;
    end
    land = ((hh - sea) * FRAC_ONE) / (32768 - sea);
    low2 = longint'(low_lvl) * 2;
    mid2 = longint'(mid_lvl) * 2;
    high2 = longint'(high_lvl) * 2;
    if (land < low2) begin
      px.rgb = lowland_c;
      px.zone = ZONE_LOWLAND;
    end else if (land < mid2) begin
      f = ((land - low2) * FRAC_ONE) / (mid2 - low2);
      if (f > FRAC_ONE) f = FRAC_ONE;
      px.rgb = blend_pixel(lowland_c, midland_c, f);
      px.zone = ZONE_LOW_MID;
    end else begin
      den = high2 - mid2;
      if (den <= 0) begin
        f = FRAC_ONE;
      end else begin
        f = ((land - mid2) * FRAC_ONE) / den;
        if (f > FRAC_ONE) f = FRAC_ONE;
        if (f < 0) f = 0;
      end
      px.rgb = blend_pixel(midland_c, highland_c, f);
      px.zone = ZONE_MID_HIGH;
    end
    return px;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("pixel %0d: %s got 0x%0h want 0x%0h", pixels_seen, what, got, want);
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin : monitor
    pixel_t want;
    height_taken = 1'b0;
    if (!rst) begin
      if (height_ch.valid && height_ch.ready) begin
        height_taken = 1'b1;
        expected_pixels.push_back(shade_height(height_ch.height_sample));
        heights_accepted++;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel", 0, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_ch.red !== want.rgb.red)
            report_mismatch("red", pixel_ch.red, want.rgb.red);
          if (pixel_ch.green !== want.rgb.green)
            report_mismatch("green", pixel_ch.green, want.rgb.green);
          if (pixel_ch.blue !== want.rgb.blue)
            report_mismatch("blue", pixel_ch.blue, want.rgb.blue);
          if (pixel_ch.zone !== want.zone)
            report_mismatch("zone", pixel_ch.zone, want.zone);
        end
        pixels_seen++;
      end
    end
  end

  // Hold the offered height until its transaction completes.
  always @(negedge clk) begin
    if (rst) begin
      height_ch.valid <= 1'b0;
    end else if (!height_ch.valid || height_taken) begin
      if (pending_heights.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        height_ch.valid <= 1'b1;
        height_ch.height_sample <= pending_heights.pop_front();
      end else begin
        height_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pixel_ch.ready <= 1'b0;
    end else begin
      pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[height_color_ramp] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SEA_LEVEL:    sea_lvl = data[HEIGHT_W-1:0];
      REG_LOW_LEVEL:    low_lvl = data[HEIGHT_W-1:0];
      REG_MIDDLE_LEVEL: mid_lvl = data[HEIGHT_W-1:0];
      REG_HIGH_LEVEL:   high_lvl = data[HEIGHT_W-1:0];
      REG_WATER_RGB:    water_c = data;
      REG_LOWLAND_RGB:  lowland_c = data;
      REG_MIDLAND_RGB:  midland_c = data;
      REG_HIGHLAND_RGB: highland_c = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Junk in the upper byte must be dropped for the level registers.
  function automatic logic [CFG_DATA_W-1:0] level_word(int unsigned v);
    return {8'($urandom_range(255)), 16'(v)};
  endfunction

  task automatic load_colors();
    write_reg(REG_WATER_RGB, 24'($urandom));
    write_reg(REG_LOWLAND_RGB, 24'($urandom));
    write_reg(REG_MIDLAND_RGB, 24'($urandom));
    write_reg(REG_HIGHLAND_RGB, 24'($urandom));
  endtask

  task automatic load_levels(bit ordered);
    int unsigned lv[$];
    if (ordered) begin
      repeat (3) lv.push_back($urandom_range(32767));
      lv.sort();
    end else begin
      repeat (3) lv.push_back($urandom_range(65535));
    end
    write_reg(REG_SEA_LEVEL, level_word($urandom_range(65535)));
    write_reg(REG_LOW_LEVEL, level_word(lv[0]));
    write_reg(REG_MIDDLE_LEVEL, level_word(lv[1]));
    write_reg(REG_HIGH_LEVEL, level_word(lv[2]));
  endtask

  // Height whose land fraction lands close to the given level.
  function automatic logic [HEIGHT_W-1:0] height_near(longint lvl);
    longint h;
    h = longint'(sea_lvl) + lvl * (32768 - longint'(sea_lvl)) / 32768
        + longint'($urandom_range(8)) - 4;
    if (h < -32768) h = -32768;
    if (h > 32767) h = 32767;
    return h[HEIGHT_W-1:0];
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(7))
      4:       return height_near(0);
      5:       return height_near(low_lvl);
      6:       return height_near(mid_lvl);
      7:       return height_near(high_lvl);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_height(logic [HEIGHT_W-1:0] h);
    pending_heights.push_back(h);
    heights_issued++;
  endtask

  task automatic drain();
    while (heights_accepted != heights_issued || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_heights(int count);
    repeat (count) push_height(pick_height());
    drain();
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: every zone and its edges.
    foreach (corner_heights[i])
      push_height(16'(corner_heights[i]));
    run_heights(PHASE_ITEMS);

    load_levels(1'b1);
    load_colors();
    run_heights(PHASE_ITEMS);

    // Lowest sea, negative low level, high level not above middle.
    write_reg(REG_SEA_LEVEL, level_word(16'h8000));
    write_reg(REG_LOW_LEVEL, level_word(16'h8000));
    write_reg(REG_MIDDLE_LEVEL, level_word(16'h7FFF));
    write_reg(REG_HIGH_LEVEL, level_word(16'h7FFF));
    write_reg(REG_WATER_RGB, 24'h000000);
    write_reg(REG_LOWLAND_RGB, 24'hFFFFFF);
    write_reg(REG_MIDLAND_RGB, 24'h000000);
    write_reg(REG_HIGHLAND_RGB, 24'hFFFFFF);
    push_height(16'h8000);
    push_height(16'sd32765);
    push_height(16'sd32766);
    push_height(16'sd32767);
    run_heights(PHASE_ITEMS);

    send_idle_pct = 55;
    recv_idle_pct = 13;
    // Highest sea: the land fraction divisor drops to one.
    load_levels(1'b1);
    write_reg(REG_SEA_LEVEL, level_word(16'h7FFF));
    load_colors();
    push_height(16'sd32766);
    push_height(16'sd32767);
    run_heights(PHASE_ITEMS);

    // Middle below low and high below middle.
    write_reg(REG_SEA_LEVEL, level_word($urandom_range(16384)));
    write_reg(REG_LOW_LEVEL, level_word(20000));
    write_reg(REG_MIDDLE_LEVEL, level_word(10000));
    write_reg(REG_HIGH_LEVEL, level_word(16'h8000));
    push_height(height_near(20000));
    push_height(height_near(25000));
    push_height(16'sd32767);
    run_heights(PHASE_ITEMS);

    load_levels(1'b0);
    load_colors();
    run_heights(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Block the output long enough to back the pipe up into the input.
    load_levels(1'b1);
    load_colors();
    repeat (PHASE_ITEMS) push_height(pick_height());
    hold_req++;
    drain();

    write_reg(REG_SEA_LEVEL, level_word(SEA_LEVEL_RESET));
    write_reg(REG_LOW_LEVEL, level_word(LOW_LEVEL_RESET));
    write_reg(REG_MIDDLE_LEVEL, level_word(MIDDLE_LEVEL_RESET));
    write_reg(REG_HIGH_LEVEL, level_word(HIGH_LEVEL_RESET));
    write_reg(REG_WATER_RGB, 24'hFFFFFF);
    write_reg(REG_LOWLAND_RGB, 24'h000000);
    write_reg(REG_MIDLAND_RGB, 24'hFFFFFF);
    write_reg(REG_HIGHLAND_RGB, 24'h000000);
    run_heights(PHASE_ITEMS);

    repeat (60) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch("pixels missing", 0, expected_pixels.size());
    if (mismatch_count == 0)
      $display("[height_color_ramp] OK");
    else
      $display("[height_color_ramp] ERROR");
    $finish;
  end

endmodule
